// File: design/assert_macros.svh
// Assertion macros used by the classifier RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define BSLPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BSLPC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BSLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bslpc_pkg.sv
// Types and constants of the button short/long press classifier.
// No dependencies.
package bslpc_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int BTN_W       = $clog2(NUM_BUTTONS);
  localparam int TRK_W       = $clog2(NUM_BUTTONS + 1);
  localparam int REG_W       = 12;

  localparam logic [REG_W-1:0] LONG_TICKS_RST  = 12'd100;
  localparam logic [REG_W-1:0] SHORT_TICKS_RST = 12'd5;
  localparam logic [REG_W-1:0] REL_TICKS_RST   = 12'd5;

  typedef enum logic [1:0] {
    REG_LONG  = 2'd0,
    REG_SHORT = 2'd1,
    REG_REL   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic pressed;
    logic rel_step;
    logic sel;
  } lane_ctl_t;

  typedef struct packed {
    logic long_hit;
    logic short_hit;
    logic rel_hit;
  } lane_stat_t;

endpackage

// File: design/bslpc_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on bslpc_pkg.
interface bslpc_in_if ();
  logic valid;
  logic ready;
  logic hour_down;
  logic up_down;
  logic dn_down;
  logic select_down;
  logic lap_down;

  modport source (output valid, hour_down, up_down, dn_down, select_down, lap_down,
                  input ready);
  modport sink (input valid, hour_down, up_down, dn_down, select_down, lap_down,
                output ready);
endinterface

interface bslpc_out_if import bslpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             click_valid;
  logic [BTN_W-1:0] click_button;
  logic             click_long;
  logic [TRK_W-1:0] tracked_button;

  modport source (output valid, click_valid, click_button, click_long, tracked_button,
                  input ready);
  modport sink (input valid, click_valid, click_button, click_long, tracked_button,
                output ready);
endinterface

// File: design/bslpc_lane.sv
// One button lane: press and release counters, scan update and threshold checks.
// Depends on bslpc_pkg.
module bslpc_lane import bslpc_pkg::*; #(
  parameter int CW = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  lane_ctl_t        ctl,
  input  logic [REG_W-1:0] long_ticks,
  input  logic [REG_W-1:0] short_ticks,
  input  logic [REG_W-1:0] rel_ticks,
  output lane_stat_t       stat
);

  localparam int CMP_W = (CW > REG_W) ? CW : REG_W;

  logic [CW-1:0]    press_r, press_nxt;
  logic [CW-1:0]    rel_r, rel_nxt;
  logic [CW-1:0]    press_inc, rel_inc, press_scan, rel_scan;
  logic [CMP_W-1:0] press_ext, rel_ext, long_ext, short_ext, relt_ext;
  logic             long_gt;

  always_comb begin
    press_inc  = (press_r == {CW{1'b1}}) ? press_r : press_r + CW'(1);
    rel_inc    = (rel_r == {CW{1'b1}}) ? rel_r : rel_r + CW'(1);
    press_scan = ctl.pressed ? press_inc : (ctl.rel_step ? '0 : press_r);
    rel_scan   = ctl.pressed ? '0 : (ctl.rel_step ? rel_inc : rel_r);
    press_ext  = CMP_W'(press_scan);
    rel_ext    = CMP_W'(rel_scan);
    long_ext   = CMP_W'(long_ticks);
    short_ext  = CMP_W'(short_ticks);
    relt_ext   = CMP_W'(rel_ticks);
    long_gt    = press_ext > long_ext;

    stat.long_hit  = ctl.sel && long_gt;
    stat.short_hit = ctl.sel && !long_gt && (press_ext > short_ext);
    stat.rel_hit   = ctl.sel && (rel_ext > relt_ext);

    press_nxt = stat.long_hit ? long_ext[CW-1:0] : press_scan;
    rel_nxt   = stat.rel_hit ? '0 : rel_scan;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      rel_r   <= '0;
    end else if (fire) begin
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
    end
  end

endmodule

// File: design/bslpc_merge.sv
// Tracking selection, click flags and registered result stage.
// Depends on bslpc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bslpc_merge import bslpc_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [NUM_BUTTONS-1:0]            pressed,
  output logic                              fire,
  output lane_ctl_t  [NUM_BUTTONS-1:0]      ctl,
  input  lane_stat_t [NUM_BUTTONS-1:0]      stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              click_valid,
  output logic [BTN_W-1:0]                  click_button,
  output logic                              click_long,
  output logic [TRK_W-1:0]                  tracked_button
);

  logic [TRK_W-1:0]       trk_r, trk_nxt, trk_scan;
  logic                   long_r, long_nxt, short_r, short_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   click_valid_r, click_valid_nxt;
  logic [BTN_W-1:0]       click_button_r, click_button_nxt;
  logic                   click_long_r, click_long_nxt;
  logic [TRK_W-1:0]       tracked_r;
  logic [NUM_BUTTONS-1:0] below, top_hit, old_hit, sel;
  logic [BTN_W-1:0]       sel_idx;
  logic                   any_pressed, seen, long_hit, short_hit, rel_hit, long_any, short_any;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      below[i] = seen;
      seen     = seen | pressed[i];
    end
    seen = 1'b0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      top_hit[i] = pressed[i] & !seen;
      seen       = seen | pressed[i];
    end
    any_pressed = |pressed;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      old_hit[i] = (trk_r == TRK_W'(i + 1));
    end
    sel = any_pressed ? top_hit : old_hit;

    sel_idx   = '0;
    long_hit  = 1'b0;
    short_hit = 1'b0;
    rel_hit   = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      ctl[i].pressed  = pressed[i];
      ctl[i].rel_step = !pressed[i] && old_hit[i] && !below[i];
      ctl[i].sel      = sel[i];
      if (sel[i]) begin
        sel_idx = sel_idx | BTN_W'(i);
      end
      long_hit  = long_hit  | stat[i].long_hit;
      short_hit = short_hit | stat[i].short_hit;
      rel_hit   = rel_hit   | stat[i].rel_hit;
    end

    trk_scan  = any_pressed ? (TRK_W'(sel_idx) + TRK_W'(1)) : trk_r;
    long_any  = long_r | long_hit;
    short_any = short_r | short_hit;

    click_valid_nxt  = rel_hit && (long_any || short_any);
    click_long_nxt   = rel_hit && long_any;
    click_button_nxt = click_valid_nxt ? sel_idx : '0;
    long_nxt         = (rel_hit && long_any) ? 1'b0 : long_any;
    short_nxt        = (rel_hit && !long_any && short_any) ? 1'b0 : short_any;
    trk_nxt          = rel_hit ? '0 : trk_scan;
    out_valid_nxt    = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r       <= '0;
      long_r      <= 1'b0;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        trk_r   <= trk_nxt;
        long_r  <= long_nxt;
        short_r <= short_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      click_valid_r  <= click_valid_nxt;
      click_button_r <= click_button_nxt;
      click_long_r   <= click_long_nxt;
      tracked_r      <= trk_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign click_valid    = click_valid_r;
  assign click_button   = click_button_r;
  assign click_long     = click_long_r;
  assign tracked_button = tracked_r;

  `BSLPC_ASSERT_ALWAYS(a_sel_onehot0, $onehot0(sel), "more than one lane selected")
  `BSLPC_ASSERT_ALWAYS(a_trk_range, trk_r <= TRK_W'(NUM_BUTTONS), "tracked code out of range")
  `BSLPC_ASSERT_IMPLIES(a_click_untracks, out_valid_r && click_valid_r, tracked_r == '0, "click left a button tracked")
  `BSLPC_ASSERT_NEXT(a_long_clears, fire && click_long_nxt, !long_r, "long flag kept after long click")

endmodule

// File: design/button_short_long_press_classifier.sv
// Channel  | Dir | Handshake        | Payload
// in_ch    | in  | valid/ready      | hour_down, up_down, dn_down, select_down, lap_down
// out_ch   | out | valid/ready      | click_valid, click_button, click_long, tracked_button
// cfg_*    | in  | cfg_we           | cfg_index, cfg_data
// One item is accepted per cycle while ready; its result is registered for the next cycle.
// All button lanes update their counters in parallel in the accepting cycle.
// The input is ready whenever the output register is empty or is being taken.
// Reset is synchronous and loads the default thresholds and clears all counters.
// Top level of the button short/long press classifier.
// Depends on bslpc_pkg, bslpc_if, bslpc_lane and bslpc_merge.
module button_short_long_press_classifier import bslpc_pkg::*; #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  bslpc_in_if.sink         in_ch,
  bslpc_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  logic [REG_W-1:0] long_ticks_r, short_ticks_r, rel_ticks_r;
  logic [NUM_BUTTONS-1:0] pressed;
  logic fire;
  lane_ctl_t  [NUM_BUTTONS-1:0] ctl;
  lane_stat_t [NUM_BUTTONS-1:0] stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r  <= LONG_TICKS_RST;
      short_ticks_r <= SHORT_TICKS_RST;
      rel_ticks_r   <= REL_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG:  long_ticks_r  <= cfg_data;
        REG_SHORT: short_ticks_r <= cfg_data;
        REG_REL:   rel_ticks_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pressed = {in_ch.lap_down, in_ch.select_down, in_ch.dn_down,
                    in_ch.up_down, in_ch.hour_down};

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bslpc_lane #(.CW(COUNT_WIDTH)) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .fire        (fire),
      .ctl         (ctl[g]),
      .long_ticks  (long_ticks_r),
      .short_ticks (short_ticks_r),
      .rel_ticks   (rel_ticks_r),
      .stat        (stat[g])
    );
  end

  bslpc_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .pressed        (pressed),
    .fire           (fire),
    .ctl            (ctl),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .click_valid    (out_ch.click_valid),
    .click_button   (out_ch.click_button),
    .click_long     (out_ch.click_long),
    .tracked_button (out_ch.tracked_button)
  );

endmodule
